[rtl/lfps_pkg.sv]
// ----------------------------------------------------------------------------
// lfps_pkg: shared definitions for the line follow pd steering block
// Widths, codes, register reset values, schedule constants and the
// transfer structs used between the pipeline modules.
// ----------------------------------------------------------------------------
package lfps_pkg;

  // field widths
  localparam int SENS_W   = 8;
  localparam int ERR_W    = 4;
  localparam int SPEED_W  = 8;
  localparam int GAIN_W   = 6;
  localparam int LIMIT_W  = 16;
  localparam int OFFSET_W = 7;
  localparam int DIR_W    = 2;
  localparam int LOST_W   = 16;
  localparam int DRIVE_W  = 12;

  // internal arithmetic width, holds base +/- correction + offset
  localparam int WIDE_W = 14;
  localparam int SAT_W  = (DRIVE_W > WIDE_W) ? DRIVE_W : WIDE_W;
  localparam int CMP_W  = (LOST_W > LIMIT_W) ? LOST_W : LIMIT_W;

  // apb port
  localparam int APB_DW    = 32;
  localparam int REG_IDX_W = 3;
  localparam int APB_AW    = REG_IDX_W + 2;

  // sensor bit positions
  localparam int SB0 = 0;
  localparam int SB1 = 1;
  localparam int SB2 = 2;
  localparam int SB3 = 3;
  localparam int SB4 = 4;
  localparam int SB5 = 5;
  localparam int SD0 = 6;
  localparam int SD5 = 7;

  // encoder error codes
  localparam logic signed [ERR_W-1:0] ERR_P7 = 4'sd7;
  localparam logic signed [ERR_W-1:0] ERR_N7 = -4'sd7;
  localparam logic signed [ERR_W-1:0] ERR_P5 = 4'sd5;
  localparam logic signed [ERR_W-1:0] ERR_N5 = -4'sd5;
  localparam logic signed [ERR_W-1:0] ERR_P4 = 4'sd4;
  localparam logic signed [ERR_W-1:0] ERR_N4 = -4'sd4;
  localparam logic signed [ERR_W-1:0] ERR_P1 = 4'sd1;
  localparam logic signed [ERR_W-1:0] ERR_N1 = -4'sd1;

  // gain schedule and clamp constants
  localparam int BASE_DROP_2  = 25;
  localparam int BASE_DROP_3  = 50;
  localparam int BASE_DROP_45 = 75;
  localparam int BASE_DROP_7  = 100;
  localparam int KP_ADD_3  = 4;
  localparam int KP_ADD_45 = 6;
  localparam int KP_ADD_7  = 3;
  localparam int KD_ADD_2  = 2;
  localparam int KD_ADD_3  = 5;
  localparam int KD_ADD_45 = 6;
  localparam int KD_ADD_7  = 5;
  localparam int CLAMP_MIN      = 10;
  localparam int THR_ODD        = 30;
  localparam int THR_LEFT_EVEN  = 50;
  localparam int THR_RIGHT_EVEN = 10;

  // steering direction codes
  typedef enum logic [DIR_W-1:0] {
    DIR_FWD   = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_RIGHT = 2'd2
  } dir_t;

  // register index codes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_MAX_SPEED    = 3'd0,
    REG_BASE_SPEED   = 3'd1,
    REG_TURN_SPEED   = 3'd2,
    REG_PROP_GAIN    = 3'd3,
    REG_DERIV_GAIN   = 3'd4,
    REG_LOST_LIMIT   = 3'd5,
    REG_RIGHT_OFFSET = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [SPEED_W-1:0]         speed_cap;
    logic [SPEED_W-1:0]         cruise_speed;
    logic [SPEED_W-1:0]         spin_speed;
    logic [GAIN_W-1:0]          prop_gain;
    logic [GAIN_W-1:0]          deriv_gain;
    logic [LIMIT_W-1:0]         gap_limit;
    logic signed [OFFSET_W-1:0] right_offset;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    speed_cap:    8'd200,
    cruise_speed: 8'd180,
    spin_speed:   8'd120,
    prop_gain:    6'd20,
    deriv_gain:   6'd10,
    gap_limit:    16'd1000,
    right_offset: 7'sd0
  };

  // tracking stage result handed to the pd stage
  typedef struct packed {
    logic signed [ERR_W-1:0] error;
    logic signed [ERR_W-1:0] prev_error;
    logic                    spin;
  } track_t;

  // saturate a wide signed value to the drive range
  function automatic logic signed [DRIVE_W-1:0] sat_drive(
    input logic signed [WIDE_W-1:0] v
  );
    logic signed [SAT_W-1:0] x;
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    x  = SAT_W'(v);
    hi = SAT_W'((2 ** (DRIVE_W - 1)) - 1);
    lo = -hi - SAT_W'(1);
    if (x > hi) begin
      x = hi;
    end else if (x < lo) begin
      x = lo;
    end
    return DRIVE_W'(x);
  endfunction

endpackage

[rtl/lfps_if.sv]
// ----------------------------------------------------------------------------
// lfps_if: sensor and steering channel interfaces
// Valid/ready channels carrying one sensor sample and one steering command.
// ----------------------------------------------------------------------------
interface lfps_in_if;
  logic                        valid;
  logic                        ready;
  logic [lfps_pkg::SENS_W-1:0] line_sensors;

  modport source(output valid, output line_sensors, input ready);
  modport sink(input valid, input line_sensors, output ready);
endinterface

interface lfps_out_if;
  logic                                valid;
  logic                                ready;
  lfps_pkg::dir_t                      direction;
  logic signed [lfps_pkg::DRIVE_W-1:0] left_drive;
  logic signed [lfps_pkg::DRIVE_W-1:0] right_drive;
  logic signed [lfps_pkg::ERR_W-1:0]   line_error;
  logic                                line_lost;

  modport source(output valid, output direction, output left_drive, output right_drive,
                 output line_error, output line_lost, input ready);
  modport sink(input valid, input direction, input left_drive, input right_drive,
               input line_error, input line_lost, output ready);
endinterface

[rtl/lfps_cfg.sv]
// ----------------------------------------------------------------------------
// lfps_cfg: configuration register file
// APB-style register bank holding speeds, gains, lost limit and offset.
// ----------------------------------------------------------------------------
module lfps_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lfps_pkg::APB_AW-1:0]   paddr,
  input  logic [lfps_pkg::APB_DW-1:0]   pwdata,
  output logic [lfps_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output lfps_pkg::cfg_t                cfg
);

  lfps_pkg::cfg_t     cfg_r;
  lfps_pkg::cfg_t     cfg_nxt;
  lfps_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx    = lfps_pkg::reg_idx_t'(paddr[lfps_pkg::APB_AW-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        lfps_pkg::REG_MAX_SPEED:
          cfg_nxt.speed_cap = pwdata[lfps_pkg::SPEED_W-1:0];
        lfps_pkg::REG_BASE_SPEED:
          cfg_nxt.cruise_speed = pwdata[lfps_pkg::SPEED_W-1:0];
        lfps_pkg::REG_TURN_SPEED:
          cfg_nxt.spin_speed = pwdata[lfps_pkg::SPEED_W-1:0];
        lfps_pkg::REG_PROP_GAIN:
          cfg_nxt.prop_gain = pwdata[lfps_pkg::GAIN_W-1:0];
        lfps_pkg::REG_DERIV_GAIN:
          cfg_nxt.deriv_gain = pwdata[lfps_pkg::GAIN_W-1:0];
        lfps_pkg::REG_LOST_LIMIT:
          cfg_nxt.gap_limit = pwdata[lfps_pkg::LIMIT_W-1:0];
        lfps_pkg::REG_RIGHT_OFFSET:
          cfg_nxt.right_offset = pwdata[lfps_pkg::OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // read decode
  always_comb begin
    unique case (idx)
      lfps_pkg::REG_MAX_SPEED:    prdata = lfps_pkg::APB_DW'(cfg_r.speed_cap);
      lfps_pkg::REG_BASE_SPEED:   prdata = lfps_pkg::APB_DW'(cfg_r.cruise_speed);
      lfps_pkg::REG_TURN_SPEED:   prdata = lfps_pkg::APB_DW'(cfg_r.spin_speed);
      lfps_pkg::REG_PROP_GAIN:    prdata = lfps_pkg::APB_DW'(cfg_r.prop_gain);
      lfps_pkg::REG_DERIV_GAIN:   prdata = lfps_pkg::APB_DW'(cfg_r.deriv_gain);
      lfps_pkg::REG_LOST_LIMIT:   prdata = lfps_pkg::APB_DW'(cfg_r.gap_limit);
      lfps_pkg::REG_RIGHT_OFFSET: prdata = lfps_pkg::APB_DW'(cfg_r.right_offset);
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= lfps_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[rtl/lfps_track.sv]
// ----------------------------------------------------------------------------
// lfps_track: sensor capture and line tracking stage
// Registers the sensor sample, encodes the position error, keeps the held
// error, previous error and lost counter, and flags the search spin.
// ----------------------------------------------------------------------------
module lfps_track (
  input  logic                           clk,
  input  logic                           rst_n,
  lfps_in_if.sink                        in_ch,
  input  logic [lfps_pkg::LIMIT_W-1:0]   gap_limit,
  input  logic                           trk_rdy,
  output logic                           trk_vld,
  output lfps_pkg::track_t               trk
);

  logic                              s1_vld_r;
  logic                              s1_vld_nxt;
  logic [lfps_pkg::SENS_W-1:0]       sens_r;
  logic                              s2_vld_r;
  logic                              s2_vld_nxt;
  lfps_pkg::track_t                  trk_r;
  lfps_pkg::track_t                  trk_nxt;
  logic signed [lfps_pkg::ERR_W-1:0] held_r;
  logic signed [lfps_pkg::ERR_W-1:0] held_nxt;
  logic signed [lfps_pkg::ERR_W-1:0] prev_r;
  logic signed [lfps_pkg::ERR_W-1:0] prev_nxt;
  logic [lfps_pkg::LOST_W-1:0]       lost_r;
  logic [lfps_pkg::LOST_W-1:0]       lost_nxt;
  logic                              s1_rdy;
  logic                              s2_rdy;
  logic                              fire;
  logic                              hit;
  logic signed [lfps_pkg::ERR_W-1:0] enc;
  logic signed [lfps_pkg::ERR_W-1:0] err;

  // stage handshake
  assign s2_rdy      = ~s2_vld_r | trk_rdy;
  assign s1_rdy      = ~s1_vld_r | s2_rdy;
  assign fire        = s1_vld_r & s2_rdy;
  assign in_ch.ready = s1_rdy;
  assign s1_vld_nxt  = s1_rdy ? in_ch.valid : s1_vld_r;
  assign s2_vld_nxt  = s2_rdy ? s1_vld_r : s2_vld_r;
  assign trk_vld     = s2_vld_r;
  assign trk         = trk_r;

  // priority encoder, first match wins
  always_comb begin
    hit = 1'b1;
    enc = '0;
    if (sens_r[lfps_pkg::SB3] & sens_r[lfps_pkg::SB2] & sens_r[lfps_pkg::SD0]) begin
      enc = lfps_pkg::ERR_P7;
    end else if (sens_r[lfps_pkg::SB3] & sens_r[lfps_pkg::SB2] & sens_r[lfps_pkg::SD5]) begin
      enc = lfps_pkg::ERR_N7;
    end else if (sens_r[lfps_pkg::SB5]) begin
      enc = lfps_pkg::ERR_N5;
    end else if (sens_r[lfps_pkg::SB0]) begin
      enc = lfps_pkg::ERR_P5;
    end else if (sens_r[lfps_pkg::SB4]) begin
      enc = lfps_pkg::ERR_N4;
    end else if (sens_r[lfps_pkg::SB1]) begin
      enc = lfps_pkg::ERR_P4;
    end else if (sens_r[lfps_pkg::SB3]) begin
      enc = lfps_pkg::ERR_N1;
    end else if (sens_r[lfps_pkg::SB2]) begin
      enc = lfps_pkg::ERR_P1;
    end else begin
      hit = 1'b0;
    end
  end

  // hold last hit, count lost ticks with saturation
  always_comb begin
    err      = hit ? enc : held_r;
    held_nxt = held_r;
    prev_nxt = prev_r;
    lost_nxt = lost_r;
    if (fire) begin
      held_nxt = err;
      prev_nxt = err;
      if (hit) begin
        lost_nxt = '0;
      end else if (!(&lost_r)) begin
        lost_nxt = lost_r + lfps_pkg::LOST_W'(1);
      end
    end
    trk_nxt.error      = err;
    trk_nxt.prev_error = prev_r;
    trk_nxt.spin       = lfps_pkg::CMP_W'(lost_nxt) > lfps_pkg::CMP_W'(gap_limit);
  end

  // control and tracking state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      held_r   <= '0;
      prev_r   <= '0;
      lost_r   <= '0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      s2_vld_r <= s2_vld_nxt;
      held_r   <= held_nxt;
      prev_r   <= prev_nxt;
      lost_r   <= lost_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s1_rdy && in_ch.valid) begin
      sens_r <= in_ch.line_sensors;
    end
    if (fire) begin
      trk_r <= trk_nxt;
    end
  end

endmodule

[rtl/lfps_pd.sv]
// ----------------------------------------------------------------------------
// lfps_pd: gain schedule, pd correction and result register
// Picks base speed and gains by error size, forms the pd correction,
// clamps the wheel drives and registers the steering command.
// ----------------------------------------------------------------------------
module lfps_pd (
  input  logic             clk,
  input  logic             rst_n,
  input  lfps_pkg::cfg_t   cfg,
  input  logic             trk_vld,
  input  lfps_pkg::track_t trk,
  output logic             trk_rdy,
  lfps_out_if.source       out_ch
);

  localparam int W = lfps_pkg::WIDE_W;
  localparam int KW = lfps_pkg::GAIN_W + 1;

  logic                                out_vld_r;
  logic                                out_vld_nxt;
  lfps_pkg::dir_t                      dir_r;
  lfps_pkg::dir_t                      dir_nxt;
  logic signed [lfps_pkg::DRIVE_W-1:0] left_r;
  logic signed [lfps_pkg::DRIVE_W-1:0] left_nxt;
  logic signed [lfps_pkg::DRIVE_W-1:0] right_r;
  logic signed [lfps_pkg::DRIVE_W-1:0] right_nxt;
  logic signed [lfps_pkg::ERR_W-1:0]   err_r;
  logic                                lost_r;
  logic                                load;
  logic [2:0]                          mag;
  logic [KW-1:0]                       kp;
  logic [KW-1:0]                       kd;
  logic signed [W-1:0]                 base_w;
  logic signed [W-1:0]                 e_w;
  logic signed [W-1:0]                 diff_w;
  logic signed [W-1:0]                 corr;
  logic signed [W-1:0]                 pl;
  logic signed [W-1:0]                 pr;
  logic signed [W-1:0]                 tl;
  logic signed [W-1:0]                 tr;
  logic signed [W-1:0]                 left_w;
  logic signed [W-1:0]                 right_w;
  logic signed [W-1:0]                 max_w;
  logic signed [W-1:0]                 turn_w;

  // clamp a wheel drive into 0, the band [min, max], or max
  function automatic logic signed [W-1:0] clamp(
    input logic signed [W-1:0] v,
    input logic signed [W-1:0] vmax
  );
    logic signed [W-1:0] r;
    r = v;
    if (v > vmax) begin
      r = vmax;
    end else if (v < W'(lfps_pkg::CLAMP_MIN)) begin
      r = '0;
    end
    return r;
  endfunction

  // result register handshake
  assign trk_rdy     = ~out_vld_r | out_ch.ready;
  assign load        = trk_vld & trk_rdy;
  assign out_vld_nxt = trk_rdy ? trk_vld : out_vld_r;

  assign mag    = trk.error[lfps_pkg::ERR_W-1] ? 3'(-trk.error) : 3'(trk.error);
  assign e_w    = W'(trk.error);
  assign diff_w = e_w - W'(trk.prev_error);
  assign max_w  = W'({1'b0, cfg.speed_cap});
  assign turn_w = W'({1'b0, cfg.spin_speed});

  // gain schedule by error size
  always_comb begin
    base_w = W'({1'b0, cfg.cruise_speed});
    kp     = {1'b0, cfg.prop_gain};
    kd     = {1'b0, cfg.deriv_gain};
    case (mag) inside
      3'd7: begin
        base_w = base_w - W'(lfps_pkg::BASE_DROP_7);
        kp     = kp + KW'(lfps_pkg::KP_ADD_7);
        kd     = kd + KW'(lfps_pkg::KD_ADD_7);
      end
      3'd2: begin
        base_w = base_w - W'(lfps_pkg::BASE_DROP_2);
        kd     = kd + KW'(lfps_pkg::KD_ADD_2);
      end
      3'd3: begin
        base_w = base_w - W'(lfps_pkg::BASE_DROP_3);
        kp     = kp + KW'(lfps_pkg::KP_ADD_3);
        kd     = kd + KW'(lfps_pkg::KD_ADD_3);
      end
      3'd4, 3'd5: begin
        base_w = base_w - W'(lfps_pkg::BASE_DROP_45);
        kp     = kp + KW'(lfps_pkg::KP_ADD_45);
        kd     = kd + KW'(lfps_pkg::KD_ADD_45);
      end
      default: ;
    endcase
  end

  // pd correction and clamped wheel drives
  assign corr = (W'(kp) * e_w) + (W'(kd) * diff_w);
  assign pl   = clamp(base_w - corr, max_w);
  assign pr   = clamp(base_w + corr + W'(cfg.right_offset), max_w);
  assign tl   = mag[0] ? W'(lfps_pkg::THR_ODD) : W'(lfps_pkg::THR_LEFT_EVEN);
  assign tr   = mag[0] ? W'(lfps_pkg::THR_ODD) : W'(lfps_pkg::THR_RIGHT_EVEN);

  // command select: search spin, turn or forward
  always_comb begin
    if (trk.spin) begin
      dir_nxt = (trk.error > 0) ? lfps_pkg::DIR_LEFT : lfps_pkg::DIR_RIGHT;
      left_w  = turn_w;
      right_w = turn_w;
    end else if (mag >= 3'd2) begin
      dir_nxt = (trk.error > 0) ? lfps_pkg::DIR_RIGHT : lfps_pkg::DIR_LEFT;
      left_w  = (pl < tl) ? corr : pl;
      right_w = (pr < tr) ? corr : pr;
    end else begin
      dir_nxt = lfps_pkg::DIR_FWD;
      left_w  = pl;
      right_w = pr;
    end
    left_nxt  = lfps_pkg::sat_drive(left_w);
    right_nxt = lfps_pkg::sat_drive(right_w);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dir_r   <= dir_nxt;
      left_r  <= left_nxt;
      right_r <= right_nxt;
      err_r   <= trk.error;
      lost_r  <= trk.spin;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.direction   = dir_r;
  assign out_ch.left_drive  = left_r;
  assign out_ch.right_drive = right_r;
  assign out_ch.line_error  = err_r;
  assign out_ch.line_lost   = lost_r;

endmodule

[rtl/line_follow_pd_steering.sv]
// The block takes one eight-bit line sensor sample per transaction and returns
// one steering command per sample, in order. It accepts a sample every clock
// cycle unless the output stalls. Three registers lie on the path: the sample
// register loaded at the accepting edge, the tracking stage that encodes the
// error and updates the held error, previous error and lost count, and the
// result register after the pd arithmetic. Each stage holds its data while the
// next one is full, so a stalled output does not drop or repeat commands.
// Write registers over the APB-style port only while no sample is in flight;
// the block does not enforce this. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
// line_follow_pd_steering: line follower pd steering controller
// Top level joining the register bank, the tracking stage and the pd stage.
// ----------------------------------------------------------------------------
module line_follow_pd_steering (
  input  logic                         clk,
  input  logic                         rst_n,
  lfps_in_if.sink                      in_ch,
  lfps_out_if.source                   out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lfps_pkg::APB_AW-1:0]  paddr,
  input  logic [lfps_pkg::APB_DW-1:0]  pwdata,
  output logic [lfps_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);

  lfps_pkg::cfg_t   cfg;
  lfps_pkg::track_t trk;
  logic             trk_vld;
  logic             trk_rdy;

  // register bank
  lfps_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sample capture and line tracking
  lfps_track u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .gap_limit (cfg.gap_limit),
    .trk_rdy   (trk_rdy),
    .trk_vld   (trk_vld),
    .trk       (trk)
  );

  // pd correction and result register
  lfps_pd u_pd (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .trk_vld (trk_vld),
    .trk     (trk),
    .trk_rdy (trk_rdy),
    .out_ch  (out_ch)
  );

`ifndef SYNTHESIS
  // a search spin never issues a forward command
  a_spin_turns: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.line_lost |-> out_ch.direction != lfps_pkg::DIR_FWD)
    else $error("search spin with forward direction");

  // a search spin drives both wheels alike
  a_spin_equal: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.line_lost |-> out_ch.left_drive == out_ch.right_drive)
    else $error("search spin with unequal drives");

  // forward only for small errors outside a spin
  a_fwd_small: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.direction == lfps_pkg::DIR_FWD |->
      (out_ch.line_error == 4'sd0 || out_ch.line_error == 4'sd1 ||
       out_ch.line_error == -4'sd1))
    else $error("forward command with large error");
`endif

endmodule
